[sv/dls_pkg.sv]
package dls_pkg;

  localparam int MAX_LIGHTS = 8;
  localparam int FRAC_BITS = 16;
  localparam int LIDX_W = $clog2(MAX_LIGHTS);
  localparam int LCNT_W = $clog2(MAX_LIGHTS + 1);
  localparam int DL_W = 64 - FRAC_BITS;
  localparam int DEN_W = 38 + DL_W;
  localparam int REM_W = DEN_W;
  localparam int ACC_W = DEN_W + 2;
  localparam int INT_W = FRAC_BITS + 1;

  typedef enum logic {
    KIND_LOAD,
    KIND_SHADE
  } kind_t;

  typedef enum logic [2:0] {
    REG_CAMERA_X    = 3'd0,
    REG_CAMERA_Y    = 3'd1,
    REG_CAMERA_Z    = 3'd2,
    REG_LIGHT_COUNT = 3'd3,
    REG_DAMPING     = 3'd4
  } reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAM_SQ,
    ST_CAM_RT,
    ST_LD_SQ,
    ST_LD_RT,
    ST_DOT,
    ST_ANG,
    ST_LL_SQ,
    ST_LL_RT,
    ST_DL,
    ST_NUM,
    ST_DEN,
    ST_INT,
    ST_CMP,
    ST_OUT
  } state_t;

  typedef struct packed {
    kind_t              kind;
    logic [2:0]         light_index;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic [31:0]        scalar;
  } item_t;

  typedef struct packed {
    logic        start;
    logic [63:0] value;
  } sqrt_req_t;

  typedef struct packed {
    logic             start;
    logic [REM_W-1:0] rem_init;
    logic [63:0]      dividend;
    logic [REM_W-1:0] divisor;
    logic [6:0]       steps;
  } div_req_t;

  function automatic logic signed [31:0] sat_diff(logic signed [31:0] a,
                                                  logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) begin
      sat_diff = d[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat_diff = d[31:0];
    end
  endfunction

endpackage

[sv/dls_front.sv]
module dls_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [231:0]    s_tdata,
  input  logic            s_tuser,
  output logic            q_valid,
  output dls_pkg::item_t  q_item,
  input  logic            q_pop
);

  dls_pkg::item_t entry [2];
  dls_pkg::item_t incoming;
  logic wptr;
  logic rptr;
  logic [1:0] fill;
  logic push;

  always_comb begin
    incoming.kind = s_tuser ? dls_pkg::KIND_SHADE : dls_pkg::KIND_LOAD;
    incoming.light_index = s_tdata[2:0];
    incoming.a_x = s_tdata[34:3];
    incoming.a_y = s_tdata[66:35];
    incoming.a_z = s_tdata[98:67];
    incoming.b_x = s_tdata[130:99];
    incoming.b_y = s_tdata[162:131];
    incoming.b_z = s_tdata[194:163];
    incoming.scalar = s_tuser ? {8'd0, s_tdata[218:195]} : s_tdata[226:195];
  end

  assign s_tready = (fill != 2'd2);
  assign push = s_tvalid && s_tready;
  assign q_valid = (fill != 2'd0);
  assign q_item = entry[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (q_pop && q_valid) begin
        rptr <= ~rptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, q_pop && q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= incoming;
    end
  end

endmodule

[sv/dls_sqrt.sv]
module dls_sqrt (
  input  logic                clk,
  input  logic                rst,
  input  dls_pkg::sqrt_req_t  req,
  output logic                done,
  output logic [31:0]         root
);

  logic        busy;
  logic [4:0]  cnt;
  logic [63:0] v;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [63:0] trial;
  logic        ge;

  assign trial = res + bitv;
  assign ge = (v >= trial);
  assign root = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= 5'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 5'd0;
        v <= req.value;
        res <= 64'd0;
        bitv <= 64'd1 << 62;
      end else if (busy) begin
        if (ge) begin
          v <= v - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[sv/dls_div.sv]
module dls_div (
  input  logic               clk,
  input  logic               rst,
  input  dls_pkg::div_req_t  req,
  output logic               done,
  output logic [63:0]        quo
);

  logic                       busy;
  logic [6:0]                 cnt;
  logic [6:0]                 steps;
  logic [dls_pkg::REM_W-1:0]  rem;
  logic [dls_pkg::REM_W-1:0]  dsr;
  logic [63:0]                dvd;
  logic [dls_pkg::REM_W:0]    r2;
  logic [dls_pkg::REM_W:0]    diff;
  logic                       ge;

  assign r2 = {rem, dvd[63]};
  assign ge = (r2 >= {1'b0, dsr});
  assign diff = r2 - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= 7'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 7'd0;
        steps <= req.steps;
        rem <= req.rem_init;
        dsr <= req.divisor;
        dvd <= req.dividend;
        quo <= 64'd0;
      end else if (busy) begin
        rem <= ge ? diff[dls_pkg::REM_W-1:0] : r2[dls_pkg::REM_W-1:0];
        quo <= {quo[62:0], ge};
        dvd <= {dvd[62:0], 1'b0};
        cnt <= cnt + 7'd1;
        if (cnt == steps - 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[sv/dls_back.sv]
module dls_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  dls_pkg::item_t     q_item,
  output logic               q_pop,
  input  logic signed [31:0] camera_x,
  input  logic signed [31:0] camera_y,
  input  logic signed [31:0] camera_z,
  input  logic [3:0]         light_count,
  input  logic [31:0]        damping,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [23:0]        m_tdata
);

  localparam int F = dls_pkg::FRAC_BITS;
  localparam int AW = dls_pkg::ACC_W;

  dls_pkg::state_t state, state_next;
  logic [2:0] step, step_next;

  logic signed [31:0] pos_x [dls_pkg::MAX_LIGHTS];
  logic signed [31:0] pos_y [dls_pkg::MAX_LIGHTS];
  logic signed [31:0] pos_z [dls_pkg::MAX_LIGHTS];
  logic signed [31:0] dir_x [dls_pkg::MAX_LIGHTS];
  logic signed [31:0] dir_y [dls_pkg::MAX_LIGHTS];
  logic signed [31:0] dir_z [dls_pkg::MAX_LIGHTS];
  logic [31:0]        gain [dls_pkg::MAX_LIGHTS];

  logic signed [31:0] n_x, n_y, n_z, h_x, h_y, h_z;
  logic [23:0] color;
  logic [dls_pkg::LCNT_W-1:0] cnt;
  logic [dls_pkg::LIDX_W-1:0] idx;
  logic [31:0] dc, dlen, ll, angle;
  logic [dls_pkg::DL_W-1:0] dl;
  logic [64:0] num;
  logic [AW-1:0] acc;
  logic [dls_pkg::INT_W-1:0] best, ival;

  logic signed [31:0] cam_k, h_k, n_k, pos_k, dir_k;
  logic signed [31:0] dsel;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [65:0] prod_sh;
  logic [AW-1:0] pp_ext;
  logic [2:0] mul_last;
  logic [37:0] a35;
  logic [63:0] dl_ext;
  logic dot_pos;
  logic [dls_pkg::DEN_W-1:0] den;

  dls_pkg::sqrt_req_t sq_req;
  dls_pkg::div_req_t  dv_req;
  logic sq_done, dv_done;
  logic [31:0] sq_root;
  logic [63:0] dv_quo;

  logic [8+dls_pkg::INT_W-1:0] r_p, g_p, b_p;

  dls_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .req  (sq_req),
    .done (sq_done),
    .root (sq_root)
  );

  dls_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dv_req),
    .done (dv_done),
    .quo  (dv_quo)
  );

  always_comb begin
    case (step[1:0])
      2'd0: begin
        cam_k = camera_x; h_k = h_x; n_k = n_x; pos_k = pos_x[idx]; dir_k = dir_x[idx];
      end
      2'd1: begin
        cam_k = camera_y; h_k = h_y; n_k = n_y; pos_k = pos_y[idx]; dir_k = dir_y[idx];
      end
      default: begin
        cam_k = camera_z; h_k = h_z; n_k = n_z; pos_k = pos_z[idx]; dir_k = dir_z[idx];
      end
    endcase
  end

  assign a35 = ({6'd0, dc} << 5) + ({6'd0, dc} << 1) + {6'd0, dc};
  assign dl_ext = {{F{1'b0}}, dl};
  assign den = acc[dls_pkg::DEN_W-1:0];
  assign dot_pos = !acc[AW-1] && (acc != '0);
  assign prod_sh = prod >>> F;
  assign pp_ext = {{(AW-64){1'b0}}, prod[63:0]};

  always_comb begin
    dsel = '0;
    mul_a = '0;
    mul_b = '0;
    case (state)
      dls_pkg::ST_CAM_SQ: begin
        dsel = dls_pkg::sat_diff(cam_k, h_k);
        mul_a = {dsel[31], dsel};
        mul_b = {dsel[31], dsel};
      end
      dls_pkg::ST_LD_SQ: begin
        dsel = dls_pkg::sat_diff(pos_k, dir_k);
        mul_a = {dsel[31], dsel};
        mul_b = {dsel[31], dsel};
      end
      dls_pkg::ST_DOT: begin
        dsel = dls_pkg::sat_diff(pos_k, dir_k);
        mul_a = {n_k[31], n_k};
        mul_b = {dsel[31], dsel};
      end
      dls_pkg::ST_LL_SQ: begin
        dsel = dls_pkg::sat_diff(pos_k, h_k);
        mul_a = {dsel[31], dsel};
        mul_b = {dsel[31], dsel};
      end
      dls_pkg::ST_DL: begin
        mul_a = {1'b0, ll};
        mul_b = {1'b0, damping};
      end
      dls_pkg::ST_NUM: begin
        mul_a = {1'b0, gain[idx]};
        mul_b = {1'b0, angle};
      end
      dls_pkg::ST_DEN: begin
        case (step[1:0])
          2'd0: begin mul_a = {1'b0, a35[31:0]}; mul_b = {1'b0, dl_ext[31:0]}; end
          2'd1: begin mul_a = {1'b0, a35[31:0]}; mul_b = {1'b0, dl_ext[63:32]}; end
          2'd2: begin mul_a = {27'd0, a35[37:32]}; mul_b = {1'b0, dl_ext[31:0]}; end
          default: begin mul_a = {27'd0, a35[37:32]}; mul_b = {1'b0, dl_ext[63:32]}; end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_comb begin
    case (state)
      dls_pkg::ST_DL, dls_pkg::ST_NUM: mul_last = 3'd0;
      dls_pkg::ST_DEN: mul_last = 3'd3;
      default: mul_last = 3'd2;
    endcase
  end

  always_comb begin
    state_next = state;
    step_next = 3'd0;
    q_pop = 1'b0;
    sq_req.start = 1'b0;
    sq_req.value = acc[63:0];
    dv_req.start = 1'b0;
    dv_req.rem_init = '0;
    dv_req.dividend = {acc[63-F:0], {F{1'b0}}};
    dv_req.divisor = {{(dls_pkg::REM_W-32){1'b0}}, dlen};
    dv_req.steps = 7'd64;
    if (state == dls_pkg::ST_INT) begin
      dv_req.rem_init = {{(dls_pkg::REM_W-65){1'b0}}, num};
      dv_req.dividend = '0;
      dv_req.divisor = den;
      dv_req.steps = 7'(F);
    end
    case (state)
      dls_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.kind == dls_pkg::KIND_SHADE) begin
            state_next = dls_pkg::ST_CAM_SQ;
          end
        end
      end
      dls_pkg::ST_CAM_SQ, dls_pkg::ST_LD_SQ, dls_pkg::ST_DOT, dls_pkg::ST_LL_SQ,
      dls_pkg::ST_DL, dls_pkg::ST_NUM, dls_pkg::ST_DEN: begin
        if (step == mul_last + 3'd1) begin
          case (state)
            dls_pkg::ST_CAM_SQ: state_next = dls_pkg::ST_CAM_RT;
            dls_pkg::ST_LD_SQ:  state_next = dls_pkg::ST_LD_RT;
            dls_pkg::ST_DOT:    state_next = dls_pkg::ST_ANG;
            dls_pkg::ST_LL_SQ:  state_next = dls_pkg::ST_LL_RT;
            dls_pkg::ST_DL:     state_next = dls_pkg::ST_NUM;
            dls_pkg::ST_NUM:    state_next = dls_pkg::ST_DEN;
            default:            state_next = dls_pkg::ST_INT;
          endcase
        end else begin
          step_next = step + 3'd1;
        end
      end
      dls_pkg::ST_CAM_RT, dls_pkg::ST_LD_RT, dls_pkg::ST_LL_RT: begin
        if (step == 3'd0) begin
          sq_req.start = 1'b1;
          step_next = 3'd1;
        end else if (sq_done) begin
          case (state)
            dls_pkg::ST_CAM_RT:
              state_next = (cnt == '0) ? dls_pkg::ST_OUT : dls_pkg::ST_LD_SQ;
            dls_pkg::ST_LD_RT: state_next = dls_pkg::ST_DOT;
            default:           state_next = dls_pkg::ST_DL;
          endcase
        end else begin
          step_next = 3'd1;
        end
      end
      dls_pkg::ST_ANG: begin
        if (step == 3'd0) begin
          if (dot_pos && dlen != 32'd0) begin
            dv_req.start = 1'b1;
            step_next = 3'd1;
          end else begin
            state_next = dls_pkg::ST_LL_SQ;
          end
        end else if (dv_done) begin
          state_next = dls_pkg::ST_LL_SQ;
        end else begin
          step_next = 3'd1;
        end
      end
      dls_pkg::ST_INT: begin
        if (step == 3'd0) begin
          if (den == '0 || {{(dls_pkg::DEN_W-65){1'b0}}, num} >= den) begin
            state_next = dls_pkg::ST_CMP;
          end else begin
            dv_req.start = 1'b1;
            step_next = 3'd1;
          end
        end else if (dv_done) begin
          state_next = dls_pkg::ST_CMP;
        end else begin
          step_next = 3'd1;
        end
      end
      dls_pkg::ST_CMP: begin
        state_next = ({1'b0, idx} + 1'b1 == cnt) ? dls_pkg::ST_OUT : dls_pkg::ST_LD_SQ;
      end
      dls_pkg::ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          state_next = dls_pkg::ST_IDLE;
        end
      end
      default: state_next = dls_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dls_pkg::ST_IDLE;
      step <= 3'd0;
    end else begin
      state <= state_next;
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == dls_pkg::ST_IDLE && q_valid) begin
      if (q_item.kind == dls_pkg::KIND_LOAD) begin
        if (int'(q_item.light_index) < dls_pkg::MAX_LIGHTS) begin
          pos_x[dls_pkg::LIDX_W'(q_item.light_index)] <= q_item.a_x;
          pos_y[dls_pkg::LIDX_W'(q_item.light_index)] <= q_item.a_y;
          pos_z[dls_pkg::LIDX_W'(q_item.light_index)] <= q_item.a_z;
          dir_x[dls_pkg::LIDX_W'(q_item.light_index)] <= q_item.b_x;
          dir_y[dls_pkg::LIDX_W'(q_item.light_index)] <= q_item.b_y;
          dir_z[dls_pkg::LIDX_W'(q_item.light_index)] <= q_item.b_z;
          gain[dls_pkg::LIDX_W'(q_item.light_index)] <= q_item.scalar;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      dls_pkg::ST_IDLE: begin
        n_x <= q_item.a_x;
        n_y <= q_item.a_y;
        n_z <= q_item.a_z;
        h_x <= q_item.b_x;
        h_y <= q_item.b_y;
        h_z <= q_item.b_z;
        color <= q_item.scalar[23:0];
        if (int'(light_count) > dls_pkg::MAX_LIGHTS) begin
          cnt <= dls_pkg::LCNT_W'(dls_pkg::MAX_LIGHTS);
        end else begin
          cnt <= dls_pkg::LCNT_W'(light_count);
        end
        best <= '0;
        idx <= '0;
      end
      dls_pkg::ST_CAM_SQ, dls_pkg::ST_LD_SQ, dls_pkg::ST_LL_SQ: begin
        if (step == 3'd0) begin
          acc <= '0;
        end else begin
          acc <= acc + pp_ext;
        end
      end
      dls_pkg::ST_DOT: begin
        if (step == 3'd0) begin
          acc <= '0;
        end else begin
          acc <= acc + {{(AW-66){prod_sh[65]}}, prod_sh};
        end
      end
      dls_pkg::ST_DL: begin
        if (step == 3'd1) begin
          dl <= prod[63:F];
        end
      end
      dls_pkg::ST_NUM: begin
        if (step == 3'd1) begin
          num <= {prod[63:0], 1'b0};
        end
      end
      dls_pkg::ST_DEN: begin
        case (step)
          3'd0: acc <= '0;
          3'd1: acc <= acc + pp_ext;
          3'd2, 3'd3: acc <= acc + (pp_ext << 32);
          default: acc <= acc + (pp_ext << 64);
        endcase
      end
      dls_pkg::ST_CAM_RT: begin
        if (sq_done) dc <= sq_root;
      end
      dls_pkg::ST_LD_RT: begin
        if (sq_done) dlen <= sq_root;
      end
      dls_pkg::ST_LL_RT: begin
        if (sq_done) ll <= sq_root;
      end
      dls_pkg::ST_ANG: begin
        if (step == 3'd0) begin
          angle <= 32'd0;
        end else if (dv_done) begin
          angle <= (dv_quo[63:32] != 32'd0) ? 32'hffff_ffff : dv_quo[31:0];
        end
      end
      dls_pkg::ST_INT: begin
        if (step == 3'd0) begin
          if (den == '0) begin
            ival <= (num != 65'd0) ? dls_pkg::INT_W'(1 << F) : '0;
          end else begin
            ival <= dls_pkg::INT_W'(1 << F);
          end
        end else if (dv_done) begin
          ival <= dv_quo[F:0];
        end
      end
      dls_pkg::ST_CMP: begin
        if (ival > best) best <= ival;
        idx <= idx + 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign r_p = {{dls_pkg::INT_W{1'b0}}, color[23:16]} * {8'd0, best};
  assign g_p = {{dls_pkg::INT_W{1'b0}}, color[15:8]} * {8'd0, best};
  assign b_p = {{dls_pkg::INT_W{1'b0}}, color[7:0]} * {8'd0, best};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == dls_pkg::ST_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == dls_pkg::ST_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= {r_p[F+7:F], g_p[F+7:F], b_p[F+7:F]};
    end
  end

endmodule

[sv/diffuse_light_shader.sv]
// Diffuse light shader.
// Input beats arrive on the s_ channel: tuser selects a light load (0) or a
// shade request (1). A load writes one entry of the eight-entry light table
// and gives no output beat. A shade request gives one output beat on the m_
// channel carrying the shaded 0xRRGGBB color.
// A two-entry queue separates input acceptance from the shading engine, so
// s_tready stays high while the queue has room, even while a result waits.
// A shade request finds the camera distance, then runs each light in use
// through the shared 32-step square root unit (two roots per light) and the
// shared one-bit-per-cycle divider (64 steps for the angle, 16 for the
// intensity). The user writes the configuration registers over the APB port
// only while the block is idle; the block does not enforce this. Reset
// clears the queue, the engine and the output register and sets the
// registers to their defaults; the light table holds no defined value until
// it is loaded. When the receiver holds m_tready low the result stays in
// the output register and the engine waits before giving the next one.
module diffuse_light_shader (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // light_index, vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z, scalar_value
  input  logic [231:0] s_tdata,
  // func
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // shaded_color
  output logic [23:0]  m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic signed [31:0] camera_x, camera_y, camera_z;
  logic [3:0]  light_count;
  logic [31:0] damping;
  logic        q_valid, q_pop;
  dls_pkg::item_t q_item;
  dls_pkg::reg_t  reg_sel;

  assign pready = 1'b1;
  assign reg_sel = dls_pkg::reg_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x <= '0;
      camera_y <= '0;
      camera_z <= '0;
      light_count <= '0;
      damping <= 32'h0001_0000;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        dls_pkg::REG_CAMERA_X:    camera_x <= pwdata;
        dls_pkg::REG_CAMERA_Y:    camera_y <= pwdata;
        dls_pkg::REG_CAMERA_Z:    camera_z <= pwdata;
        dls_pkg::REG_LIGHT_COUNT: light_count <= pwdata[3:0];
        dls_pkg::REG_DAMPING:     damping <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      dls_pkg::REG_CAMERA_X:    prdata = camera_x;
      dls_pkg::REG_CAMERA_Y:    prdata = camera_y;
      dls_pkg::REG_CAMERA_Z:    prdata = camera_z;
      dls_pkg::REG_LIGHT_COUNT: prdata = {28'd0, light_count};
      dls_pkg::REG_DAMPING:     prdata = damping;
      default:                  prdata = 32'd0;
    endcase
  end

  dls_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  dls_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .camera_x    (camera_x),
    .camera_y    (camera_y),
    .camera_z    (camera_z),
    .light_count (light_count),
    .damping     (damping),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule

[bench/testbench.sv]
module testbench;
  import dls_pkg::*;

  localparam int LIMIT = 20_000_000;
  localparam int ONE_Q = 1 << FRAC_BITS;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [231:0] s_tdata;
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [23:0]  m_tdata;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [4:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  diffuse_light_shader u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  item_t       pending_beats[$];
  logic [23:0] colors_due[$];
  item_t       cur_beat;
  int          errors = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  logic signed [31:0] cam_x, cam_y, cam_z;
  logic [3:0]         lights_used;
  logic [31:0]        damp;
  logic signed [31:0] lpx[MAX_LIGHTS], lpy[MAX_LIGHTS], lpz[MAX_LIGHTS];
  logic signed [31:0] ldx[MAX_LIGHTS], ldy[MAX_LIGHTS], ldz[MAX_LIGHTS];
  logic [31:0]        lgain[MAX_LIGHTS];

  function automatic longint clamp_diff(logic signed [31:0] a, logic signed [31:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d > 64'sd2147483647) d = 64'sd2147483647;
    if (d < -64'sd2147483648) d = -64'sd2147483648;
    return d;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [63:0] magnitude(longint x, longint y, longint z);
    logic [63:0] ax, ay, az;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    az = z < 0 ? -z : z;
    return int_sqrt(ax * ax + ay * ay + az * az);
  endfunction

  function automatic logic [63:0] light_level(int i, item_t it);
    longint       dx, dy, dz, dot;
    logic [63:0]  dlen, ang, ll, dl, dc;
    logic [127:0] num, den, q;
    dx = clamp_diff(lpx[i], ldx[i]);
    dy = clamp_diff(lpy[i], ldy[i]);
    dz = clamp_diff(lpz[i], ldz[i]);
    dlen = magnitude(dx, dy, dz);
    dot = ((longint'(it.a_x) * dx) >>> FRAC_BITS) + ((longint'(it.a_y) * dy) >>> FRAC_BITS)
        + ((longint'(it.a_z) * dz) >>> FRAC_BITS);
    ang = 0;
    if (dot > 0 && dlen != 0) begin
      ang = (64'(dot) << FRAC_BITS) / dlen;
      if (ang > 64'hFFFF_FFFF) ang = 64'hFFFF_FFFF;
    end
    ll = magnitude(clamp_diff(lpx[i], it.b_x), clamp_diff(lpy[i], it.b_y),
                   clamp_diff(lpz[i], it.b_z));
    dl = (ll * 64'(damp)) >> FRAC_BITS;
    dc = magnitude(clamp_diff(cam_x, it.b_x), clamp_diff(cam_y, it.b_y),
                   clamp_diff(cam_z, it.b_z));
    num = 128'(lgain[i]) * 128'(ang) * 128'd2;
    den = 128'(dc) * 128'd35 * 128'(dl);
    if (den == 0) return (num != 0) ? ONE_Q : 0;
    q = (num << FRAC_BITS) / den;
    return (q >= ONE_Q) ? ONE_Q : q[63:0];
  endfunction

  function automatic logic [23:0] shade_color(item_t it);
    logic [63:0] best, v, r, g, b;
    int          n;
    best = 0;
    n = (lights_used > MAX_LIGHTS) ? MAX_LIGHTS : lights_used;
    for (int i = 0; i < n; i++) begin
      v = light_level(i, it);
      if (v > best) best = v;
    end
    r = (64'(it.scalar[23:16]) * best) >> FRAC_BITS;
    g = (64'(it.scalar[15:8]) * best) >> FRAC_BITS;
    b = (64'(it.scalar[7:0]) * best) >> FRAC_BITS;
    return {r[7:0], g[7:0], b[7:0]};
  endfunction

  function automatic logic [31:0] coord(int span);
    if ($urandom_range(0, 9) == 0) return $urandom;
    return 32'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic item_t mk(kind_t k, logic [2:0] idx, logic [31:0] ax, logic [31:0] ay,
                               logic [31:0] az, logic [31:0] bx, logic [31:0] by,
                               logic [31:0] bz, logic [31:0] sc);
    item_t it;
    it.kind = k;
    it.light_index = idx;
    it.a_x = ax; it.a_y = ay; it.a_z = az;
    it.b_x = bx; it.b_y = by; it.b_z = bz;
    it.scalar = sc;
    return it;
  endfunction

  function automatic item_t random_beat();
    if ($urandom_range(0, 99) < 35)
      return mk(KIND_LOAD, 3'($urandom), coord(8 * ONE_Q), coord(8 * ONE_Q), coord(8 * ONE_Q),
                coord(8 * ONE_Q), coord(8 * ONE_Q), coord(8 * ONE_Q),
                $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 1 << 24)));
    return mk(KIND_SHADE, 3'($urandom), coord(2 * ONE_Q), coord(2 * ONE_Q), coord(2 * ONE_Q),
              coord(8 * ONE_Q), coord(8 * ONE_Q), coord(8 * ONE_Q), $urandom);
  endfunction

  task automatic write_reg(reg_t r, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (r)
      REG_CAMERA_X:    cam_x = value;
      REG_CAMERA_Y:    cam_y = value;
      REG_CAMERA_Z:    cam_z = value;
      REG_LIGHT_COUNT: lights_used = value[3:0];
      REG_DAMPING:     damp = value;
      default: ;
    endcase
  endtask

  task automatic drain();
    wait (pending_beats.size() == 0 && !s_tvalid && colors_due.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic setup(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                       logic [3:0] cnt, logic [31:0] dmp);
    write_reg(REG_CAMERA_X, cx);
    write_reg(REG_CAMERA_Y, cy);
    write_reg(REG_CAMERA_Z, cz);
    write_reg(REG_LIGHT_COUNT, cnt);
    write_reg(REG_DAMPING, dmp);
  endtask

  task automatic add_random(int n);
    for (int i = 0; i < n; i++) pending_beats.push_back(random_beat());
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (cur_beat.kind == KIND_LOAD) begin
          lpx[cur_beat.light_index] = cur_beat.a_x;
          lpy[cur_beat.light_index] = cur_beat.a_y;
          lpz[cur_beat.light_index] = cur_beat.a_z;
          ldx[cur_beat.light_index] = cur_beat.b_x;
          ldy[cur_beat.light_index] = cur_beat.b_y;
          ldz[cur_beat.light_index] = cur_beat.b_z;
          lgain[cur_beat.light_index] = cur_beat.scalar;
        end else begin
          colors_due.push_back(shade_color(cur_beat));
        end
      end
      if (!s_tvalid || s_tready) begin
        if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_beat = pending_beats.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= cur_beat.kind;
          s_tdata <= {5'b0, cur_beat.scalar, cur_beat.b_z, cur_beat.b_y, cur_beat.b_x,
                      cur_beat.a_z, cur_beat.a_y, cur_beat.a_x, cur_beat.light_index};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (colors_due.size() == 0) begin
          $error("unexpected beat shaded_color=%h", m_tdata);
          errors++;
        end else begin
          logic [23:0] want;
          want = colors_due.pop_front();
          if (want !== m_tdata) begin
            $error("shaded_color expected %h actual %h", want, m_tdata);
            errors++;
          end
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cam_x = 0; cam_y = 0; cam_z = 0;
    lights_used = 0;
    damp = ONE_Q;
    send_idle_pct = 10;
    recv_idle_pct = 56;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // With no lights in use the one shade request comes out black; the loads then fill all eight table entries.
    pending_beats.push_back(mk(KIND_SHADE, 0, ONE_Q, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    pending_beats.push_back(mk(KIND_LOAD, 0, 0, 0, 4 * ONE_Q, 0, 0, 0, 50 * ONE_Q));
    pending_beats.push_back(mk(KIND_LOAD, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF));
    pending_beats.push_back(mk(KIND_LOAD, 2, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q,
                               100 * ONE_Q));
    pending_beats.push_back(mk(KIND_LOAD, 3, 3 * ONE_Q, 0, 0, 0, 0, 0, 0));
    for (int i = 4; i < MAX_LIGHTS; i++) begin
      pending_beats.push_back(mk(KIND_LOAD, 3'(i), coord(6 * ONE_Q), coord(6 * ONE_Q),
                                 coord(6 * ONE_Q), coord(ONE_Q), coord(ONE_Q), coord(ONE_Q),
                                 $urandom_range(0, 1 << 24)));
    end
    drain();

    setup(0, 0, 0, 8, ONE_Q);
    pending_beats.push_back(mk(KIND_SHADE, 0, 0, 0, ONE_Q, 0, 0, 0, 32'h00FF_80FF));
    pending_beats.push_back(mk(KIND_SHADE, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               ONE_Q, 2 * ONE_Q, 0, 32'hFFFF_FFFF));
    pending_beats.push_back(mk(KIND_SHADE, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               32'h7FFF_FFFF, 32'h8000_0000, 0, 32'hFF12_3456));
    pending_beats.push_back(mk(KIND_SHADE, 0, 0, 0, -ONE_Q, ONE_Q, ONE_Q, ONE_Q, 32'hFFFFFF));
    pending_beats.push_back(mk(KIND_SHADE, 0, 0, 0, ONE_Q, 0, 0, 2 * ONE_Q, 0));
    add_random(470);
    drain();

    send_idle_pct = 56;
    recv_idle_pct = 10;
    setup(32'h7FFF_FFFF, 32'h8000_0000, coord(4 * ONE_Q), 15, 32'hFFFF_FFFF);
    pending_beats.push_back(mk(KIND_SHADE, 0, ONE_Q, ONE_Q, ONE_Q, 32'h7FFF_FFFF,
                               32'h8000_0000, 0, 32'h00FF_FFFF));
    add_random(470);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    setup(coord(4 * ONE_Q), coord(4 * ONE_Q), coord(4 * ONE_Q), 3, 0);
    add_random(470);
    drain();

    setup(coord(4 * ONE_Q), coord(4 * ONE_Q), coord(4 * ONE_Q),
          4'($urandom_range(1, MAX_LIGHTS)), $urandom_range(1, 4 * ONE_Q));
    add_random(470);
    drain();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
sv/dls_pkg.sv
sv/dls_front.sv
sv/dls_sqrt.sv
sv/dls_div.sv
sv/dls_back.sv
sv/diffuse_light_shader.sv
bench/testbench.sv
